// ----- rtl/pedd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the palette error-diffusion ditherer.
// No dependencies; imported by pedd_match and the top level.
package pedd_pkg;

	localparam int PIX_W     = 8;
	localparam int RGB_W     = 24;
	localparam int NUM_CH    = 3;
	localparam int CH_W      = 13;               // signed sixteenths per channel
	localparam int LINE_W    = NUM_CH * CH_W;
	localparam int DIST_W    = 10;               // up to 3 * 255
	localparam int IDX_W     = 4;
	localparam int NUM_LEAF  = 16;
	localparam int NUM_PAIRS = 8;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_W     = 2 * RGB_W;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [RGB_W-1:0] rgb_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] distance;
		rgb_t              rgb;
	} cand_t;

	// Palette entries keep red in the top byte, blue in the bottom byte.
	function automatic pix_t chan_of(input rgb_t rgb, input logic [1:0] ch);
		pix_t r;
		case (ch)
			CH_RED:   r = rgb[23:16];
			CH_GREEN: r = rgb[15:8];
			default:  r = rgb[7:0];
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/pedd_match.sv -----
`timescale 1ns / 1ps
// Nearest palette entry search: Manhattan distances registered in stage 1,
// min tree (lowest index on a tie) in stage 2. Depends on pedd_pkg.
module pedd_match import pedd_pkg::*; #(
	parameter int PALETTE_SIZE = 16
) (
	input  logic                  clk,
	input  logic                  load,
	input  logic [NUM_CH-1:0][PIX_W-1:0] adj,
	input  rgb_t                  pal [PALETTE_SIZE],
	output cand_t                 best
);

	logic [DIST_W-1:0] dist_s2 [PALETTE_SIZE];
	cand_t leaf [NUM_LEAF];
	cand_t lvl1 [NUM_LEAF/2];
	cand_t lvl2 [NUM_LEAF/4];
	cand_t lvl3 [NUM_LEAF/8];

	function automatic pix_t abs_diff(input pix_t a, input pix_t b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic cand_t pick(input cand_t a, input cand_t b);
		return (b.distance < a.distance) ? b : a;
	endfunction

	for (genvar e = 0; e < PALETTE_SIZE; e++) begin : g_dist
		logic [DIST_W-1:0] d;
		always_comb begin
			d = DIST_W'(abs_diff(adj[0], chan_of(pal[e], 2'd0)))
			  + DIST_W'(abs_diff(adj[1], chan_of(pal[e], 2'd1)))
			  + DIST_W'(abs_diff(adj[2], chan_of(pal[e], 2'd2)));
		end
		always_ff @(posedge clk) begin
			if (load) begin
				dist_s2[e] <= d;
			end
		end
	end

	for (genvar e = 0; e < NUM_LEAF; e++) begin : g_leaf
		if (e < PALETTE_SIZE) begin : g_used
			assign leaf[e] = '{idx: IDX_W'(e), distance: dist_s2[e], rgb: pal[e]};
		end else begin : g_pad
			assign leaf[e] = '{idx: IDX_W'(e), distance: DIST_MAX, rgb: '0};
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_LEAF/2; i++) lvl1[i] = pick(leaf[2*i], leaf[2*i+1]);
		for (int i = 0; i < NUM_LEAF/4; i++) lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
		for (int i = 0; i < NUM_LEAF/8; i++) lvl3[i] = pick(lvl2[2*i], lvl2[2*i+1]);
		best = pick(lvl3[0], lvl3[1]);
	end

endmodule

// ----- rtl/palette_error_diffusion_dither_top.sv -----
`timescale 1ns / 1ps
// A pixel is registered in stage 1 on acceptance, then in stage 2, then in the output register.
// No new pixel is accepted while one is in stage 1, a limit set by the right-carry loop
// (error add and saturation in stage 1, palette min tree and new error in stage 2).
// Reset: control state and palette cleared; the line store is not cleared,
// the first row after reset or frame start reads it as zero.
module palette_error_diffusion_dither_top import pedd_pkg::*; #(
	parameter int MAX_WIDTH    = 1024,
	parameter int PALETTE_SIZE = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,   // red, green, blue
	input  logic                 s_axis_tlast,   // row_last
	input  logic                 s_axis_tuser,   // frame_start
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,   // palette_index, chosen_red, chosen_green, chosen_blue, pad
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [CW-1:0] LAST_COL = CW'(MAX_WIDTH - 1);

	// palette registers
	rgb_t pal_q [PALETTE_SIZE];

	assign cfg_ready = 1'b1;

	for (genvar e = 0; e < PALETTE_SIZE; e++) begin : g_pal
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pal_q[e] <= '0;
			end else if (cfg_valid && cfg_index == CFG_IDX_W'(e / 2)) begin
				pal_q[e] <= cfg_data[(e % 2) * RGB_W +: RGB_W];
			end
		end
	end

	// pipeline control
	logic valid_s1, valid_s2, out_valid_q;
	logic s2_adv, acc;

	// row state
	logic [CW-1:0]     column_count_q;
	logic              first_row_q;
	logic [LINE_W-1:0] rc_q, bp_q, brp_q;

	// stage registers
	logic [23:0]       rgb_s1;
	logic [CW-1:0]     col_s1, col_s2;
	logic              fr_s1, fr_s2, fs_s1, fs_s2, last_s1, last_s2;
	logic [NUM_CH-1:0][PIX_W-1:0] adj_s1, adj_s2;

	// line store and forwarding
	logic [LINE_W-1:0] line_mem [MAX_WIDTH];
	logic [LINE_W-1:0] rd_q, line_s1;
	logic              fa_valid_q, fb_valid_q, pend_q;
	logic [CW-1:0]     fa_addr_q, fb_addr_q;
	logic [LINE_W-1:0] fa_data_q, fb_data_q;
	logic              wr_en;
	logic [CW-1:0]     wr_addr;
	logic [LINE_W-1:0] wr_data;

	// accept-time values
	logic [CW-1:0] cnt_cur, col_acc;
	logic          fr_cur, fr_acc, last_acc;

	// stage 2 results
	cand_t             best;
	logic [LINE_W-1:0] wa, nb, rc_new, err_w;
	logic [27:0]       out_data_q;

	assign s2_adv        = valid_s2 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 && (!valid_s2 || s2_adv);
	assign acc           = s_axis_tvalid && s_axis_tready;

	// the row state may be updating on the very edge that accepts the next pixel
	always_comb begin
		cnt_cur  = s2_adv ? (last_s2 ? '0 : col_s2 + CW'(1)) : column_count_q;
		fr_cur   = s2_adv ? (!last_s2 && fr_s2) : first_row_q;
		col_acc  = s_axis_tuser ? '0 : cnt_cur;
		fr_acc   = s_axis_tuser || fr_cur;
		last_acc = s_axis_tlast || (col_acc == LAST_COL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			out_valid_q    <= 1'b0;
			column_count_q <= '0;
			first_row_q    <= 1'b1;
			rc_q           <= '0;
			bp_q           <= '0;
			brp_q          <= '0;
			fa_valid_q     <= 1'b0;
			fb_valid_q     <= 1'b0;
			pend_q         <= 1'b0;
		end else begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1 || (valid_s2 && !s2_adv);
			pend_q   <= s2_adv && last_s2;
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (s2_adv) begin
				fa_valid_q <= (col_s2 != '0);
				fb_valid_q <= last_s2;
				if (last_s2) begin
					column_count_q <= '0;
					first_row_q    <= 1'b0;
					rc_q           <= '0;
					bp_q           <= '0;
					brp_q          <= '0;
				end else begin
					column_count_q <= col_s2 + CW'(1);
					first_row_q    <= fr_s2;
					rc_q           <= rc_new;
					bp_q           <= nb;
					brp_q          <= err_w;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			rgb_s1  <= s_axis_tdata;
			col_s1  <= col_acc;
			fr_s1   <= fr_acc;
			fs_s1   <= s_axis_tuser;
			last_s1 <= last_acc;
		end
		if (valid_s1) begin
			adj_s2  <= adj_s1;
			col_s2  <= col_s1;
			fr_s2   <= fr_s1;
			fs_s2   <= fs_s1;
			last_s2 <= last_s1;
		end
		if (s2_adv) begin
			fa_addr_q  <= col_s2 - CW'(1);
			fa_data_q  <= wa;
			fb_addr_q  <= col_s2;
			fb_data_q  <= nb;
			out_data_q <= {best.rgb[7:0], best.rgb[15:8], best.rgb[23:16], best.idx};
		end
	end

	// line store: one read at acceptance, at most one write per edge
	always_comb begin
		wr_en   = pend_q || (s2_adv && col_s2 != '0);
		wr_addr = pend_q ? fb_addr_q : col_s2 - CW'(1);
		wr_data = pend_q ? fb_data_q : wa;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q <= line_mem[col_acc];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_addr] <= wr_data;
		end
	end

	// newest writes override the read, which sees the store before them
	always_comb begin
		if (fb_valid_q && fb_addr_q == col_s1) begin
			line_s1 = fb_data_q;
		end else if (fa_valid_q && fa_addr_q == col_s1) begin
			line_s1 = fa_data_q;
		end else begin
			line_s1 = rd_q;
		end
	end

	// stage 1: add diffused error, truncate sixteenths toward zero, saturate
	always_comb begin
		logic signed [CH_W-1:0] rc_c, ln_c;
		logic signed [CH_W:0]   sum;
		logic signed [CH_W:0]   sum_r;
		logic signed [CH_W-4:0] q;
		logic signed [PIX_W+2:0] v;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			rc_c  = fs_s1 ? '0 : rc_q[ch*CH_W +: CH_W];
			ln_c  = fr_s1 ? '0 : line_s1[ch*CH_W +: CH_W];
			sum   = {rc_c[CH_W-1], rc_c} + {ln_c[CH_W-1], ln_c};
			sum_r = sum + (sum[CH_W] ? (CH_W+1)'(15) : (CH_W+1)'(0));
			q     = sum_r[CH_W:4];
			v     = {3'b000, rgb_s1[ch*PIX_W +: PIX_W]} + {q[CH_W-4], q};
			if (v[PIX_W+2]) begin
				adj_s1[ch] = '0;
			end else if (v[PIX_W+1:PIX_W] != 2'b00) begin
				adj_s1[ch] = '1;
			end else begin
				adj_s1[ch] = v[PIX_W-1:0];
			end
		end
	end

	pedd_match #(
		.PALETTE_SIZE(PALETTE_SIZE)
	) u_match (
		.clk  (clk),
		.load (valid_s1),
		.adj  (adj_s1),
		.pal  (pal_q),
		.best (best)
	);

	// stage 2: error against the chosen color, spread to neighbors
	always_comb begin
		logic signed [PIX_W:0]  err9;
		logic signed [CH_W-1:0] e13, bp_c, brp_c;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			err9  = {1'b0, adj_s2[ch]} - {1'b0, chan_of(best.rgb, 2'(ch))};
			e13   = {{(CH_W-PIX_W-1){err9[PIX_W]}}, err9};
			bp_c  = fs_s2 ? '0 : bp_q[ch*CH_W +: CH_W];
			brp_c = fs_s2 ? '0 : brp_q[ch*CH_W +: CH_W];
			err_w[ch*CH_W +: CH_W]  = e13;
			wa[ch*CH_W +: CH_W]     = bp_c + (e13 <<< 1) + e13;
			nb[ch*CH_W +: CH_W]     = brp_c + (e13 <<< 2) + e13;
			rc_new[ch*CH_W +: CH_W] = (e13 <<< 3) - e13;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_data_q};

endmodule

// ----- bench/tb_palette_error_diffusion_dither_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for palette_error_diffusion_dither_top: a dithering predictor runs
// beside the block and every output transaction is compared in order against it.
// Depends on rtl/pedd_pkg.sv and rtl/palette_error_diffusion_dither_top.sv.
module tb_palette_error_diffusion_dither_top;
	import pedd_pkg::*;

	localparam int LINE_LEN   = 1024;
	localparam int PAL_LEN    = 16;
	localparam int FAR_DIST   = 100000;
	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		logic [IDX_W-1:0] idx;
		pix_t             red;
		pix_t             green;
		pix_t             blue;
	} dither_out_t;

	typedef enum int {
		PAL_RANDOM,
		PAL_BLACK,
		PAL_WHITE,
		PAL_PAIRS_DUP,
		PAL_EXTREMES
	} pal_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata = '0;   // red, green, blue
	logic                 s_axis_tlast = 1'b0; // row_last
	logic                 s_axis_tuser = 1'b0; // frame_start
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [31:0]          m_axis_tdata;        // palette_index, red, green, blue, pad
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	palette_error_diffusion_dither_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Predictor state, error terms in signed sixteenths
	rgb_t pal_rgb [PAL_LEN] = '{default: '0};
	int   carry_right [NUM_CH] = '{default: 0};
	int   part_below [NUM_CH] = '{default: 0};
	int   part_below_right [NUM_CH] = '{default: 0};
	int   line_err [LINE_LEN][NUM_CH];
	int   col_pos = 0;
	bit   top_row = 1'b1;
	int   line_extent = 0;   // columns below this were written since reset

	dither_out_t expected_colors [$];
	int          err_count = 0;
	int          idle_cycles = 0;
	bit          burst_mode = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic pix_t chan(input rgb_t c, input int ch);
		return c[23 - 8 * ch -: 8];
	endfunction

	function automatic void clear_row();
		for (int ch = 0; ch < NUM_CH; ch++) begin
			carry_right[ch] = 0;
			part_below[ch] = 0;
			part_below_right[ch] = 0;
		end
		col_pos = 0;
	endfunction

	function automatic dither_out_t dither_pixel(input rgb_t px, input bit row_end,
			input bit new_frame);
		int adj [NUM_CH];
		int err [NUM_CH];
		int acc, d, diff, best_d, best_i, c, nb;
		bit row_done;
		dither_out_t res;
		if (new_frame) begin
			clear_row();
			top_row = 1'b1;
		end
		c = (col_pos >= LINE_LEN) ? LINE_LEN - 1 : col_pos;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			acc = carry_right[ch];
			if (!top_row)
				acc += line_err[c][ch];
			adj[ch] = int'(chan(px, ch)) + acc / 16;
			if (adj[ch] < 0)
				adj[ch] = 0;
			if (adj[ch] > 255)
				adj[ch] = 255;
		end
		best_d = FAR_DIST;
		best_i = 0;
		for (int i = 0; i < PAL_LEN; i++) begin
			d = 0;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				diff = int'(chan(pal_rgb[i], ch)) - adj[ch];
				d += (diff < 0) ? -diff : diff;
			end
			// strict compare keeps the lowest index on a tie
			if (d < best_d) begin
				best_d = d;
				best_i = i;
			end
		end
		for (int ch = 0; ch < NUM_CH; ch++)
			err[ch] = adj[ch] - int'(chan(pal_rgb[best_i], ch));
		row_done = row_end || (c == LINE_LEN - 1);
		for (int ch = 0; ch < NUM_CH; ch++) begin
			if (c > 0)
				line_err[c - 1][ch] = part_below[ch] + 3 * err[ch];
			nb = part_below_right[ch] + 5 * err[ch];
			part_below_right[ch] = err[ch];
			part_below[ch] = nb;
			carry_right[ch] = 7 * err[ch];
		end
		if (c > line_extent)
			line_extent = c;
		if (row_done) begin
			// 7/16 and 1/16 beyond the right edge are dropped
			for (int ch = 0; ch < NUM_CH; ch++)
				line_err[c][ch] = part_below[ch];
			if (c + 1 > line_extent)
				line_extent = c + 1;
			clear_row();
			top_row = 1'b0;
		end else begin
			col_pos = c + 1;
		end
		res.idx = best_i[IDX_W-1:0];
		res.red = chan(pal_rgb[best_i], 0);
		res.green = chan(pal_rgb[best_i], 1);
		res.blue = chan(pal_rgb[best_i], 2);
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic rgb_t rand_color();
		rgb_t c;
		c = rgb_t'($urandom);
		for (int ch = 0; ch < NUM_CH; ch++)
			if ($urandom_range(0, 9) == 0)
				c[8 * ch +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return c;
	endfunction

	function automatic logic [CFG_W-1:0] rand_pair();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[CFG_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic send_pixel(input rgb_t px, input bit row_end, input bit new_frame);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {px[7:0], px[15:8], px[23:16]};
		s_axis_tlast <= row_end;
		s_axis_tuser <= new_frame;
		do @(posedge clk); while (!s_axis_tready);
		expected_colors.push_back(dither_pixel(px, row_end, new_frame));
	endtask

	// Never let a later row read a line store column that was never written
	task automatic send_guarded(input rgb_t px, input bit row_end, input bit new_frame);
		bit fs;
		fs = new_frame;
		if (!fs && !top_row && col_pos >= line_extent)
			fs = 1'b1;
		send_pixel(px, row_end, fs);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_PAIRS) begin
			pal_rgb[2 * idx] = value[23:0];
			pal_rgb[2 * idx + 1] = value[47:24];
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_colors.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_palette(input pal_kind_t kind);
		rgb_t ent [PAL_LEN];
		for (int i = 0; i < PAL_LEN; i++) begin
			case (kind)
				PAL_BLACK:     ent[i] = '0;
				PAL_WHITE:     ent[i] = '1;
				PAL_PAIRS_DUP: ent[i] = (i % 2 == 1) ? ent[i - 1] : rgb_t'($urandom);
				PAL_EXTREMES: begin
					for (int ch = 0; ch < NUM_CH; ch++)
						ent[i][8 * ch +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				end
				default:       ent[i] = rgb_t'($urandom);
			endcase
		end
		wait_idle();
		for (int k = 0; k < NUM_PAIRS; k++)
			cfg_write(CFG_IDX_W'(k), {ent[2 * k + 1], ent[2 * k]});
		if ($urandom_range(0, 1))
			cfg_write(CFG_IDX_W'($urandom_range(NUM_PAIRS, 15)), rand_pair());
	endtask

	task automatic run_random_frames(input int n_items);
		int sent, rows, width, len, burst_len;
		bit fs_frame, fs, last;
		sent = 0;
		while (sent < n_items) begin
			burst_mode = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 19) == 0) begin
				// noise: flags at random
				burst_len = $urandom_range(5, 25);
				for (int b = 0; b < burst_len && sent < n_items; b++) begin
					send_guarded(rand_color(), $urandom_range(0, 1) == 1,
						$urandom_range(0, 4) == 0);
					sent++;
				end
			end else begin
				rows = $urandom_range(1, 8);
				width = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) :
					$urandom_range(1, 40);
				fs_frame = ($urandom_range(0, 9) != 0);
				for (int r = 0; r < rows && sent < n_items; r++) begin
					len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, width + 10) : width;
					if (!top_row && !(r == 0 && fs_frame) && len > line_extent)
						len = line_extent;
					for (int j = 0; j < len && sent < n_items; j++) begin
						fs = (r == 0 && j == 0 && fs_frame);
						last = (j == len - 1);
						if ($urandom_range(0, 49) == 0)
							last = ~last;
						if ($urandom_range(0, 59) == 0)
							fs = 1'b1;
						send_guarded(rand_color(), last, fs);
						sent++;
					end
				end
			end
		end
		burst_mode = 1'b0;
	endtask

	// All-zero palette after reset: every entry ties, index 0 wins
	task automatic test_reset_palette();
		send_pixel(24'hFFFFFF, 1'b0, 1'b1);
		send_pixel(24'h00FF80, 1'b0, 1'b0);
		send_pixel(24'h7F7F7F, 1'b1, 1'b0);
	endtask

	task automatic test_directed_pixels();
		wait_idle();
		cfg_write(0, {24'hFFFFFF, 24'h000000});
		cfg_write(1, {24'h00FF00, 24'hFF0000});
		cfg_write(2, {24'h808080, 24'h0000FF});
		cfg_write(3, {24'hFFFF00, 24'h808080});   // entry 6 repeats entry 5
		cfg_write(4, {24'h00FFFF, 24'hFF00FF});
		cfg_write(5, {24'h404040, 24'hC0C0C0});
		cfg_write(6, {24'h7F0000, 24'h00007F});
		cfg_write(7, {24'hFFFFFF, 24'h007F00});   // entry 15 repeats entry 1
		// first row of a frame, line store read as zero
		send_pixel(24'h000000, 1'b0, 1'b1);
		send_pixel(24'hFFFFFF, 1'b0, 1'b0);
		send_pixel(24'h808080, 1'b0, 1'b0);
		send_pixel(24'hFF0000, 1'b0, 1'b0);
		send_pixel(24'h00FF00, 1'b0, 1'b0);
		send_pixel(24'h0000FF, 1'b1, 1'b0);
		// saturation low then high through the right carry
		send_pixel(24'h646464, 1'b0, 1'b0);
		send_pixel(24'h050505, 1'b0, 1'b0);
		send_pixel(24'h3C3C3C, 1'b0, 1'b0);
		send_pixel(24'hFAFAFA, 1'b0, 1'b0);
		send_pixel(24'hC81E5A, 1'b0, 1'b0);
		send_pixel(24'hFFFFFF, 1'b1, 1'b0);
		// shorter row, then back to full width
		send_pixel(24'h0AF00A, 1'b0, 1'b0);
		send_pixel(24'h000000, 1'b0, 1'b0);
		send_pixel(24'h7F7F7F, 1'b1, 1'b0);
		send_pixel(24'hFFFF00, 1'b0, 1'b0);
		send_pixel(24'h123456, 1'b0, 1'b0);
		send_pixel(24'hFEDCBA, 1'b0, 1'b0);
		send_pixel(24'h00FFFF, 1'b0, 1'b0);
		send_pixel(24'h808081, 1'b0, 1'b0);
		send_pixel(24'h010101, 1'b1, 1'b0);
		// frame start in the middle of a row
		send_pixel(24'hAAAAAA, 1'b0, 1'b0);
		send_pixel(24'h555555, 1'b0, 1'b0);
		send_pixel(24'hFFFFFF, 1'b1, 1'b1);
	endtask

	// Indexes past the last pair must leave the palette alone
	task automatic test_unmapped_index();
		wait_idle();
		for (int k = NUM_PAIRS; k < 16; k++)
			cfg_write(CFG_IDX_W'(k), rand_pair());
		send_pixel(24'h0000FF, 1'b0, 1'b1);
		send_pixel(24'hFF00FF, 1'b0, 1'b0);
		send_pixel(24'h404040, 1'b0, 1'b0);
		send_pixel(24'hC0C0C0, 1'b1, 1'b0);
	endtask

	// No tlast: the row ends on its own at the last column
	task automatic test_overlong_row();
		load_palette(PAL_RANDOM);
		for (int j = 0; j < LINE_LEN; j++)
			send_pixel(rand_color(), 1'b0, j == 0);
		for (int j = 0; j < 8; j++)
			send_pixel(rand_color(), j == 7, 1'b0);
	endtask

	task automatic test_random_dither();
		pal_kind_t kind;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0:       kind = PAL_EXTREMES;
				1:       kind = PAL_BLACK;
				2:       kind = PAL_WHITE;
				3:       kind = PAL_PAIRS_DUP;
				default: kind = PAL_RANDOM;
			endcase
			load_palette(kind);
			run_random_frames(48);
		end
	endtask

	// Output sink with random backpressure
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 99) < 30)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		dither_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_colors.size() == 0) begin
				report_mismatch("output transaction with nothing expected");
			end else begin
				want = expected_colors.pop_front();
				if (m_axis_tdata[3:0] !== want.idx)
					report_mismatch($sformatf("palette_index %0h, want %0h",
						m_axis_tdata[3:0], want.idx));
				if (m_axis_tdata[11:4] !== want.red)
					report_mismatch($sformatf("chosen_red %0h, want %0h",
						m_axis_tdata[11:4], want.red));
				if (m_axis_tdata[19:12] !== want.green)
					report_mismatch($sformatf("chosen_green %0h, want %0h",
						m_axis_tdata[19:12], want.green));
				if (m_axis_tdata[27:20] !== want.blue)
					report_mismatch($sformatf("chosen_blue %0h, want %0h",
						m_axis_tdata[27:20], want.blue));
			end
		end
	end

	// Watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL palette_error_diffusion_dither_top");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_palette();
		test_directed_pixels();
		test_unmapped_index();
		test_overlong_row();
		test_random_dither();
		wait_idle();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("PASS palette_error_diffusion_dither_top");
		else
			$display("FAIL palette_error_diffusion_dither_top");
		$finish;
	end

endmodule

// ----- palette_error_diffusion_dither_top.f -----
rtl/pedd_pkg.sv
rtl/pedd_match.sv
rtl/palette_error_diffusion_dither_top.sv
bench/tb_palette_error_diffusion_dither_top.sv
